[hw/rtl/button_speed_setpoint_with_period_core_defines.svh]
// Assertion macros for the button speed setpoint core.
// Used by files that check their own logic; expects clk and arst_n in scope.
`ifndef BUTTON_SPEED_SETPOINT_WITH_PERIOD_CORE_DEFINES_SVH
`define BUTTON_SPEED_SETPOINT_WITH_PERIOD_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSSP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSSP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/bssp_pkg.sv]
// Shared types and constants for the button speed setpoint core.
// No dependencies.
package bssp_pkg;

	localparam int SPEED_W   = 16;
	localparam int TOOTH_W   = 8;
	localparam int PROD_W    = SPEED_W + TOOTH_W;
	localparam int NUM_W     = 32;
	localparam int PERIOD_W  = 16;
	localparam int APB_DW    = 32;
	localparam int APB_AW    = 5;

	localparam int MUL_STEPS = TOOTH_W;
	localparam int DIV_STEPS = NUM_W;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	localparam logic [PERIOD_W-1:0] PERIOD_STOPPED = 16'hFFFF;

	localparam logic [SPEED_W-1:0] RST_STEP      = 16'd100;
	localparam logic [SPEED_W-1:0] RST_FWD_LIMIT = 16'hFFFF;
	localparam logic [SPEED_W-1:0] RST_REV_LIMIT = 16'hFFFF;
	localparam logic [TOOTH_W-1:0] RST_TOOTH     = 8'd60;
	localparam logic [NUM_W-1:0]   RST_NUM       = 32'd1000000;

	typedef enum logic [2:0] {
		REG_BIDI    = 3'd0,
		REG_STEP    = 3'd1,
		REG_FWD_LIM = 3'd2,
		REG_REV_LIM = 3'd3,
		REG_TOOTH   = 3'd4,
		REG_NUM     = 3'd5
	} bssp_reg_t;

	typedef struct packed {
		logic up_pressed;
		logic down_pressed;
	} bssp_in_t;

	typedef struct packed {
		logic [SPEED_W-1:0]  speed_value;
		logic                reverse_direction;
		logic [PERIOD_W-1:0] period_count;
	} bssp_out_t;

	typedef struct packed {
		logic busy;
		logic done;
	} bssp_unit_stat_t;

endpackage

[hw/rtl/bssp_mul.sv]
// Bit-serial shift-and-add multiplier: speed times tooth count, one bit a cycle.
// Depends on bssp_pkg.
module bssp_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [bssp_pkg::SPEED_W-1:0]      mcand,
	input  logic [bssp_pkg::TOOTH_W-1:0]      mplier,
	output bssp_pkg::bssp_unit_stat_t         stat,
	output logic [bssp_pkg::PROD_W-1:0]       product
);
	import bssp_pkg::*;

	logic [PROD_W-1:0]    acc_q;
	logic [PROD_W-1:0]    mcand_q;
	logic [TOOTH_W-1:0]   mplier_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= MUL_CNT_W'(MUL_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MUL_CNT_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	// Add the shifted multiplicand when the low multiplier bit is set.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= PROD_W'(mcand);
			mplier_q <= mplier;
		end else if (cnt_q != '0) begin
			if (mplier_q[0])
				acc_q <= acc_q + mcand_q;
			mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[TOOTH_W-1:1]};
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign product   = acc_q;

endmodule

[hw/rtl/bssp_div.sv]
// Restoring bit-serial divider: one quotient bit a cycle, low bits returned.
// Depends on bssp_pkg.
module bssp_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [bssp_pkg::NUM_W-1:0]        dividend,
	input  logic [bssp_pkg::PROD_W-1:0]       divisor,
	output bssp_pkg::bssp_unit_stat_t         stat,
	output logic [bssp_pkg::PERIOD_W-1:0]     quotient
);
	import bssp_pkg::*;

	logic [PROD_W-1:0]    rem_q;
	logic [NUM_W-1:0]     quo_q;
	logic [PROD_W-1:0]    dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [PROD_W:0]      shifted;
	logic [PROD_W+1:0]    diff;
	logic                 ge;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign ge      = !diff[PROD_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= DIV_CNT_W'(DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	// Shift in the next dividend bit, subtract when it fits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[PROD_W-1:0] : shifted[PROD_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign quotient  = quo_q[PERIOD_W-1:0];

endmodule

[hw/rtl/button_speed_setpoint_with_period_core.sv]
// Top level of the button speed setpoint core: registers, speed update, sequencing.
// Depends on bssp_pkg, bssp_mul, bssp_div and the assertion macro header.
//
//  channel | direction | handshake         | beat
//  --------+-----------+-------------------+---------------------------------
//  in      | sink      | in_valid/in_stall | up_pressed, down_pressed
//  out     | source    | out_valid/out_stall | speed_value, reverse_direction,
//          |           |                   |   period_count
//  apb     | sink      | psel/penable      | six setup registers at 4*index
//
// A sample goes from accept to result in steps: speed update (ST_UP, then
// ST_DN), the serial multiply, the 32-step divide, and a load of the output
// register. The core then returns to idle and can take the next sample.
// When speed or tooth count is zero the divide is skipped.
// in_stall is high while a sample is at work; a finished result waits in the
// output register, so the next sample is taken while out_stall holds it.
// Reset clears speed, direction and registers to their defaults; no sweep.
`include "button_speed_setpoint_with_period_core_defines.svh"

module button_speed_setpoint_with_period_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// sample input
	input  logic                              in_valid,
	output logic                              in_stall,
	input  bssp_pkg::bssp_in_t                in_data,
	// result output
	output logic                              out_valid,
	input  logic                              out_stall,
	output bssp_pkg::bssp_out_t               out_data,
	// register port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bssp_pkg::APB_AW-1:0]       paddr,
	input  logic [bssp_pkg::APB_DW-1:0]       pwdata,
	output logic [bssp_pkg::APB_DW-1:0]       prdata,
	output logic                              pready
);
	import bssp_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_UP   = 6'b000010,
		ST_DN   = 6'b000100,
		ST_MUL  = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		OP_AWAY,
		OP_TOWARD,
		OP_UNI_DN
	} step_op_t;

	// setup registers
	logic                 bidi_q;
	logic [SPEED_W-1:0]   step_q;
	logic [SPEED_W-1:0]   fwd_lim_q;
	logic [SPEED_W-1:0]   rev_lim_q;
	logic [TOOTH_W-1:0]   tooth_q;
	logic [NUM_W-1:0]     num_q;

	// control and speed state
	state_t               st_q;
	logic [SPEED_W-1:0]   speed_q;
	logic                 dir_q;
	logic                 branch_q;
	logic                 up_q;
	logic                 down_q;
	logic [PERIOD_W-1:0]  period_q;
	logic                 out_valid_q;
	bssp_out_t            out_data_q;

	// update datapath
	logic [SPEED_W-1:0]   speed_d;
	logic                 dir_d;
	logic                 act;
	step_op_t             op;
	logic [SPEED_W-1:0]   lim;
	logic                 flip;
	logic [SPEED_W:0]     sum_w;
	logic [SPEED_W-1:0]   diff_w;

	// serial units
	logic                 mul_start;
	logic                 div_start;
	bssp_unit_stat_t      mul_stat;
	bssp_unit_stat_t      div_stat;
	logic [PROD_W-1:0]    product;
	logic [PERIOD_W-1:0]  quotient;

	logic                 in_acc;
	logic                 out_free;
	logic                 cfg_wr;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign cfg_wr   = psel && penable && pwrite;

	// ---------------------------------------------------------------
	// Register port: always ready, index taken from the word address.
	// ---------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bidi_q    <= 1'b0;
			step_q    <= RST_STEP;
			fwd_lim_q <= RST_FWD_LIMIT;
			rev_lim_q <= RST_REV_LIMIT;
			tooth_q   <= RST_TOOTH;
			num_q     <= RST_NUM;
		end else if (cfg_wr) begin
			case (bssp_reg_t'(paddr[APB_AW-1:2]))
				REG_BIDI:    bidi_q    <= pwdata[0];
				REG_STEP:    step_q    <= pwdata[SPEED_W-1:0];
				REG_FWD_LIM: fwd_lim_q <= pwdata[SPEED_W-1:0];
				REG_REV_LIM: rev_lim_q <= pwdata[SPEED_W-1:0];
				REG_TOOTH:   tooth_q   <= pwdata[TOOTH_W-1:0];
				REG_NUM:     num_q     <= pwdata;
				default:     ;
			endcase
		end
	end

	always_comb begin
		case (bssp_reg_t'(paddr[APB_AW-1:2]))
			REG_BIDI:    prdata = APB_DW'(bidi_q);
			REG_STEP:    prdata = APB_DW'(step_q);
			REG_FWD_LIM: prdata = APB_DW'(fwd_lim_q);
			REG_REV_LIM: prdata = APB_DW'(rev_lim_q);
			REG_TOOTH:   prdata = APB_DW'(tooth_q);
			REG_NUM:     prdata = num_q;
			default:     prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Speed update: up button in ST_UP, down button in ST_DN. The branch
	// follows the direction latched when the beat was taken, so a flip
	// made by the up button does not change how down is handled.
	// ---------------------------------------------------------------
	assign sum_w  = {1'b0, speed_q} + {1'b0, step_q};
	assign diff_w = speed_q - step_q;

	always_comb begin
		act     = 1'b0;
		op      = OP_AWAY;
		lim     = fwd_lim_q;
		flip    = 1'b0;
		speed_d = speed_q;
		dir_d   = dir_q;

		case (st_q)
			ST_UP: begin
				act = up_q;
				if (bidi_q && branch_q) begin
					op   = OP_TOWARD;
					flip = 1'b0;
				end else begin
					op  = OP_AWAY;
					lim = fwd_lim_q;
				end
			end
			ST_DN: begin
				act = down_q;
				if (!bidi_q) begin
					op = OP_UNI_DN;
				end else if (!branch_q) begin
					op   = OP_TOWARD;
					flip = 1'b1;
				end else begin
					op  = OP_AWAY;
					lim = rev_lim_q;
				end
			end
			default: act = 1'b0;
		endcase

		if (act) begin
			case (op)
				// step away only when the unwrapped sum stays within the limit
				OP_AWAY: begin
					if (sum_w <= {1'b0, lim})
						speed_d = sum_w[SPEED_W-1:0];
				end
				// step toward zero; landing on zero or pressing at zero flips
				OP_TOWARD: begin
					if (speed_q >= step_q) begin
						speed_d = diff_w;
						if (diff_w == '0)
							dir_d = flip;
					end else if (speed_q == '0) begin
						dir_d   = flip;
						speed_d = step_q;
					end
				end
				// unidirectional: never step down onto zero
				OP_UNI_DN: begin
					if (speed_q > step_q)
						speed_d = diff_w;
				end
				default: speed_d = speed_q;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Serial units: start the multiply as the down step settles, using
	// the new speed; start the divide only for a nonzero product.
	// ---------------------------------------------------------------
	assign mul_start = (st_q == ST_DN);
	assign div_start = (st_q == ST_MUL) && mul_stat.done && (product != '0);

	bssp_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (speed_d),
		.mplier  (tooth_q),
		.stat    (mul_stat),
		.product (product)
	);

	bssp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (num_q),
		.divisor  (product),
		.stat     (div_stat),
		.quotient (quotient)
	);

	// ---------------------------------------------------------------
	// Sequencer and state
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			speed_q     <= '0;
			dir_q       <= 1'b0;
			branch_q    <= 1'b0;
			up_q        <= 1'b0;
			down_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			speed_q <= speed_d;
			dir_q   <= dir_d;

			// load the result when the output register is free, drop it
			// once the sink takes it
			if (st_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						up_q     <= in_data.up_pressed;
						down_q   <= in_data.down_pressed;
						branch_q <= dir_q;
						st_q     <= ST_UP;
					end
				end
				ST_UP:  st_q <= ST_DN;
				ST_DN:  st_q <= ST_MUL;
				ST_MUL: begin
					if (mul_stat.done)
						st_q <= (product == '0) ? ST_OUT : ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done)
						st_q <= ST_OUT;
				end
				ST_OUT: begin
					// hold until the output register is free
					if (out_free)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers: no reset needed
	always_ff @(posedge clk) begin
		if (st_q == ST_MUL && mul_stat.done && product == '0)
			period_q <= PERIOD_STOPPED;
		else if (st_q == ST_DIV && div_stat.done)
			period_q <= quotient;

		if (st_q == ST_OUT && out_free) begin
			out_data_q.speed_value       <= speed_q;
			out_data_q.reverse_direction <= dir_q;
			out_data_q.period_count      <= period_q;
		end
	end

	assign in_stall  = (st_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	`BSSP_ASSERT_NXT(a_accept_starts_update, in_acc, st_q == ST_UP, "accepted beat did not start update")
	`BSSP_ASSERT_NXT(a_uni_keeps_dir, !bidi_q, $stable(dir_q), "direction moved in unidirectional mode")
	`BSSP_ASSERT_IMP(a_idle_units_quiet, st_q == ST_IDLE, !mul_stat.busy && !div_stat.busy, "serial unit busy while idle")

endmodule

[tb/testbench.sv]
// Self-checking bench for button_speed_setpoint_with_period_core: directed table, then random.
// Depends on bssp_pkg and the core; predicts every result beat and checks it field by field.
module testbench;
	import bssp_pkg::*;

	// No activity at all for this many cycles means the core hung. Idle gaps
	// and output stalls run at 16 percent, so long runs of them are rare. The
	// limit leaves a wide margin over all of it.
	localparam int HANG_LIMIT  = 4000;
	localparam int DRAIN_TAIL  = 64;
	localparam int IDLE_PCT    = 16;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 125;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	// One row of the directed plan: a register write or a sample. A sample
	// either carries a hand-typed result (known) or defers to the predictor.
	typedef struct {
		row_kind_t   kind;
		bssp_reg_t   which;
		logic [31:0] value;
		bssp_in_t    sample;
		logic        known;
		bssp_out_t   want;
	} plan_row_t;

	logic                clk     = 1'b0;
	logic                arst_n  = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	bssp_in_t            in_data = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	bssp_out_t           out_data;
	logic                psel    = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite  = 1'b0;
	logic [APB_AW-1:0]   paddr   = '0;
	logic [APB_DW-1:0]   pwdata  = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	// Shadow copy of the setup registers, at their reset values.
	logic                cfg_bidi  = 1'b0;
	logic [SPEED_W-1:0]  cfg_step  = RST_STEP;
	logic [SPEED_W-1:0]  cfg_fwd   = RST_FWD_LIMIT;
	logic [SPEED_W-1:0]  cfg_rev   = RST_REV_LIMIT;
	logic [TOOTH_W-1:0]  cfg_tooth = RST_TOOTH;
	logic [NUM_W-1:0]    cfg_num   = RST_NUM;

	// Predicted speed state.
	logic [SPEED_W-1:0]  speed_now   = '0;
	logic                reverse_now = 1'b0;

	bssp_out_t           pending_setpoints[$];
	plan_row_t           plan[$];

	logic                idling_on = 1'b0;
	int                  mismatches = 0;
	int                  samples_sent = 0;
	int                  results_checked = 0;
	int                  reg_writes = 0;
	int                  quiet_cycles = 0;

	always #6 clk = ~clk;

	button_speed_setpoint_with_period_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// ------------------------------------------------------------------
	// Speed predictor
	// ------------------------------------------------------------------

	// Move one step away from zero; the sum is taken one bit wider so a step
	// past the limit is refused instead of wrapping.
	function automatic void step_away(input logic [SPEED_W-1:0] limit);
		logic [SPEED_W:0] sum;
		sum = {1'b0, speed_now} + {1'b0, cfg_step};
		if (sum <= {1'b0, limit})
			speed_now = sum[SPEED_W-1:0];
	endfunction

	// Move one step toward zero. Landing on zero flips the direction; a press
	// made at zero flips it and moves one step out the other side.
	function automatic void step_toward(input logic flip_to);
		if (speed_now >= cfg_step) begin
			speed_now = speed_now - cfg_step;
			if (speed_now == '0)
				reverse_now = flip_to;
		end else if (speed_now == '0) begin
			reverse_now = flip_to;
			speed_now   = cfg_step;
		end
	endfunction

	// Advance the predicted state by one button sample and return the beat
	// the core should send for it.
	function automatic bssp_out_t next_setpoint(input bssp_in_t s);
		logic              was_reverse;
		logic [PROD_W-1:0] product;
		logic [NUM_W-1:0]  quotient;
		bssp_out_t         r;
		// the branch is fixed by the direction at the start of the sample,
		// even when the up button flips it on the way
		was_reverse = reverse_now;
		if (cfg_bidi) begin
			if (!was_reverse) begin
				if (s.up_pressed)
					step_away(cfg_fwd);
				if (s.down_pressed)
					step_toward(1'b1);
			end else begin
				if (s.up_pressed)
					step_toward(1'b0);
				if (s.down_pressed)
					step_away(cfg_rev);
			end
		end else begin
			// one-way mode never steps down to zero and keeps the direction
			if (s.up_pressed)
				step_away(cfg_fwd);
			if (s.down_pressed && speed_now > cfg_step)
				speed_now = speed_now - cfg_step;
		end
		product = PROD_W'(speed_now) * PROD_W'(cfg_tooth);
		r.speed_value       = speed_now;
		r.reverse_direction = reverse_now;
		if (product == '0) begin
			r.period_count = PERIOD_STOPPED;
		end else begin
			quotient       = cfg_num / NUM_W'(product);
			r.period_count = quotient[PERIOD_W-1:0];
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Plan building
	// ------------------------------------------------------------------

	function automatic void add_write(input bssp_reg_t which, input logic [31:0] value);
		plan_row_t row;
		row.kind   = ROW_WRITE;
		row.which  = which;
		row.value  = value;
		row.sample = '0;
		row.known  = 1'b0;
		row.want   = '0;
		plan.push_back(row);
	endfunction

	function automatic void add_sample(input logic up, input logic dn);
		plan_row_t row;
		row.kind   = ROW_SAMPLE;
		row.which  = REG_BIDI;
		row.value  = '0;
		row.sample = '{up_pressed: up, down_pressed: dn};
		row.known  = 1'b0;
		row.want   = '0;
		plan.push_back(row);
	endfunction

	function automatic void add_known(input logic up, input logic dn, input logic [15:0] spd,
			input logic rev, input logic [15:0] per);
		plan_row_t row;
		row.kind   = ROW_SAMPLE;
		row.which  = REG_BIDI;
		row.value  = '0;
		row.sample = '{up_pressed: up, down_pressed: dn};
		row.known  = 1'b1;
		row.want   = '{speed_value: spd, reverse_direction: rev, period_count: per};
		plan.push_back(row);
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Offer one sample and hold it until the core takes it. On the accepting
	// edge, record the expected beat: the typed one if given, else predicted.
	task automatic push_sample(input bssp_in_t s, input logic known, input bssp_out_t want);
		bssp_out_t predicted;
		while (idling_on && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = next_setpoint(s);
		pending_setpoints.push_back(known ? want : predicted);
		samples_sent++;
	endtask

	// Drop valid and wait until every expected beat has come back, so the
	// core is idle and the registers may change.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_setpoints.size() != 0)
			@(posedge clk);
	endtask

	// Write one register through the APB port, then read it back. The shadow
	// copy is updated first; nothing is in flight while this runs.
	task automatic program_reg(input bssp_reg_t which, input logic [31:0] value);
		logic [31:0] stored;
		case (which)
			REG_BIDI: begin
				cfg_bidi = value[0];
				stored   = {31'b0, value[0]};
			end
			REG_STEP: begin
				cfg_step = value[SPEED_W-1:0];
				stored   = {16'b0, value[SPEED_W-1:0]};
			end
			REG_FWD_LIM: begin
				cfg_fwd = value[SPEED_W-1:0];
				stored  = {16'b0, value[SPEED_W-1:0]};
			end
			REG_REV_LIM: begin
				cfg_rev = value[SPEED_W-1:0];
				stored  = {16'b0, value[SPEED_W-1:0]};
			end
			REG_TOOTH: begin
				cfg_tooth = value[TOOTH_W-1:0];
				stored    = {24'b0, value[TOOTH_W-1:0]};
			end
			REG_NUM: begin
				cfg_num = value;
				stored  = value;
			end
			default: stored = '0;
		endcase
		// setup, then access for the write
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {which, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		// same address again as a read
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== stored) begin
			$error("register %s: expected %0h, got %0h", which.name(), stored, prdata);
			mismatches++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		reg_writes++;
	endtask

	function automatic logic [15:0] pick_step();
		case ($urandom_range(5))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			2, 3:    return 16'($urandom_range(1, 300));
			default: return 16'($urandom_range(1, 5000));
		endcase
	endfunction

	function automatic logic [15:0] pick_limit();
		case ($urandom_range(5))
			0:       return 16'd0;
			1, 2:    return 16'hFFFF;
			3:       return 16'($urandom_range(1, 3000));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Fresh random settings for every register, extremes weighted in.
	task automatic random_settings();
		logic [7:0]  teeth;
		logic [31:0] num;
		case ($urandom_range(3))
			0:       teeth = 8'd0;
			1:       teeth = 8'hFF;
			default: teeth = 8'($urandom_range(1, 255));
		endcase
		case ($urandom_range(4))
			0:       num = 32'd0;
			1:       num = 32'hFFFF_FFFF;
			2:       num = RST_NUM;
			default: num = $urandom;
		endcase
		program_reg(REG_BIDI, 32'($urandom_range(1)));
		program_reg(REG_STEP, {16'b0, pick_step()});
		program_reg(REG_FWD_LIM, {16'b0, pick_limit()});
		program_reg(REG_REV_LIM, {16'b0, pick_limit()});
		program_reg(REG_TOOTH, {24'b0, teeth});
		program_reg(REG_NUM, num);
	endtask

	// Random button traffic in bursts that lean one way, so the speed climbs
	// to its limits and comes back down through zero instead of hovering.
	task automatic random_phase(input int count);
		int left;
		int run;
		int lean;
		bit up;
		bit dn;
		left = count;
		while (left > 0) begin
			run  = $urandom_range(5, 40);
			lean = $urandom_range(3);
			while (run > 0 && left > 0) begin
				case (lean)
					0: begin
						up = ($urandom_range(99) < 85);
						dn = ($urandom_range(99) < 10);
					end
					1: begin
						up = ($urandom_range(99) < 10);
						dn = ($urandom_range(99) < 85);
					end
					2: begin
						up = ($urandom_range(99) < 60);
						dn = ($urandom_range(99) < 60);
					end
					default: begin
						up = $urandom_range(1);
						dn = $urandom_range(1);
					end
				endcase
				push_sample('{up_pressed: up, down_pressed: dn}, 1'b0, '0);
				run--;
				left--;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Output side: stall at random and check every accepted beat
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (idling_on)
			out_stall <= ($urandom_range(99) < IDLE_PCT);
		else
			out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		bssp_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_setpoints.size() == 0) begin
				$error("result beat with nothing expected: speed %0d dir %0d period %0d",
					out_data.speed_value, out_data.reverse_direction, out_data.period_count);
				mismatches++;
			end else begin
				want = pending_setpoints.pop_front();
				results_checked++;
				if (out_data.speed_value !== want.speed_value) begin
					$error("speed_value: expected %0d, got %0d",
						want.speed_value, out_data.speed_value);
					mismatches++;
				end
				if (out_data.reverse_direction !== want.reverse_direction) begin
					$error("reverse_direction: expected %0d, got %0d",
						want.reverse_direction, out_data.reverse_direction);
					mismatches++;
				end
				if (out_data.period_count !== want.period_count) begin
					$error("period_count: expected %0d, got %0d",
						want.period_count, out_data.period_count);
					mismatches++;
				end
			end
		end
	end

	// Hang detection: any beat on either channel or an APB access counts as
	// progress and resets the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("timeout: no progress for %0d cycles", HANG_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		// One-way mode from reset: step 100, 60 teeth, numerator 1000000.
		add_known(1'b0, 1'b0, 16'd0, 1'b0, 16'hFFFF);    // nothing pressed after reset
		add_known(1'b0, 1'b1, 16'd0, 1'b0, 16'hFFFF);    // down at zero is ignored
		add_sample(1'b1, 1'b0);
		add_sample(1'b1, 1'b0);
		add_sample(1'b0, 1'b1);
		add_sample(1'b0, 1'b1);                          // at one step: down refused
		add_sample(1'b1, 1'b1);                          // up applies before down
		add_write(REG_FWD_LIM, 32'd150);
		add_sample(1'b1, 1'b0);                          // step would pass the limit
		// Two-way mode: pass through zero.
		add_write(REG_BIDI, 32'd1);
		add_write(REG_FWD_LIM, 32'hFFFF);
		add_known(1'b0, 1'b1, 16'd0, 1'b1, 16'hFFFF);    // land on zero, flip to reverse
		add_sample(1'b0, 1'b1);                          // away from zero in reverse
		add_known(1'b1, 1'b0, 16'd0, 1'b0, 16'hFFFF);    // land on zero, flip to forward
		add_write(REG_STEP, 32'd0);
		add_known(1'b0, 1'b1, 16'd0, 1'b1, 16'hFFFF);    // zero step: flip only
		add_known(1'b1, 1'b0, 16'd0, 1'b0, 16'hFFFF);
		add_write(REG_STEP, 32'd100);
		add_sample(1'b0, 1'b1);                          // press at zero: flip and step out
		add_sample(1'b1, 1'b1);                          // branch stays reverse after flip
		add_sample(1'b1, 1'b1);
		add_write(REG_STEP, 32'hFFFF);
		add_sample(1'b1, 1'b0);                          // step larger than the limit
		add_sample(1'b0, 1'b1);                          // below one step, not zero: hold
		add_write(REG_STEP, 32'd100);
		add_write(REG_REV_LIM, 32'd0);
		add_known(1'b0, 1'b1, 16'd0, 1'b1, 16'hFFFF);
		add_known(1'b0, 1'b1, 16'd0, 1'b1, 16'hFFFF);    // reverse limit zero blocks
		add_sample(1'b1, 1'b0);
		add_write(REG_TOOTH, 32'd0);
		add_known(1'b0, 1'b0, 16'd100, 1'b0, 16'hFFFF);  // zero teeth: stopped period
		add_write(REG_TOOTH, 32'd255);
		add_write(REG_NUM, 32'd0);
		add_known(1'b0, 1'b0, 16'd100, 1'b0, 16'd0);     // zero numerator
		add_write(REG_NUM, 32'hFFFF_FFFF);
		add_sample(1'b0, 1'b0);                          // quotient wider than 16 bits
		add_write(REG_STEP, 32'd65435);
		add_sample(1'b1, 1'b0);                          // reach full-scale speed

		repeat (12) @(posedge clk);
		arst_n    <= 1'b1;
		idling_on <= 1'b1;
		@(posedge clk);

		// Walk the directed plan; writes wait for the core to go idle.
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				drain();
				program_reg(plan[i].which, plan[i].value);
			end else begin
				push_sample(plan[i].sample, plan[i].known, plan[i].want);
			end
		end

		// Random phases, each under fresh settings. One phase runs with no
		// idling on either side so back-to-back beats are exercised.
		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			random_settings();
			idling_on <= (phase != 3);
			random_phase(PHASE_ITEMS);
		end

		drain();
		repeat (DRAIN_TAIL) @(posedge clk);

		$display("covered %0d button samples and %0d result beats over %0d register writes",
			samples_sent, results_checked, reg_writes);
		$display("both directions, limits, zero crossings and period extremes; %0d mismatches",
			mismatches);
		if (mismatches == 0 && pending_setpoints.size() == 0) begin
			$display("status: pass");
		end else begin
			if (pending_setpoints.size() != 0)
				$error("%0d expected result beats never arrived", pending_setpoints.size());
			$display("status: fail");
		end
		$finish;
	end

endmodule
